FILE: hdl/tdfa_pkg.sv
// ----------------------------------------------------------------------------
// tdfa_pkg
// shared types and constants of the table driven automaton stepper
// ----------------------------------------------------------------------------
package tdfa_pkg;

    localparam int MAX_STATES_DEF  = 256;
    localparam int SYMBOL_BITS_DEF = 8;
    localparam int MARK_BITS_DEF   = 16;

    localparam int REQ_W   = 3;
    localparam int STATE_W = 8;
    localparam int SYM_W   = 8;
    localparam int MIDX_W  = 4;
    localparam int MASK_W  = 16;

    typedef enum logic [REQ_W-1:0] {
        REQ_LOAD    = 3'd0,
        REQ_STOP    = 3'd1,
        REQ_MARK    = 3'd2,
        REQ_RESTART = 3'd3,
        REQ_STEP    = 3'd4
    } req_t;

    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [STATE_W-1:0] from_state;
        logic [SYM_W-1:0]   symbol;
        logic [STATE_W-1:0] to_state;
        logic               flag_value;
        logic [MIDX_W-1:0]  mark_index;
    } in_t;

    typedef struct packed {
        logic [STATE_W-1:0] cur_state;
        logic               rejected;
        logic               accepting;
        logic [MASK_W-1:0]  mark_mask;
    } out_t;

endpackage

FILE: hdl/table_driven_dfa_stepper_top.sv
// ----------------------------------------------------------------------------
// table_driven_dfa_stepper_top
// table driven automaton engine: loads transitions, stop flags and marks,
// restarts and steps symbols, one status beat per request beat
// ----------------------------------------------------------------------------
//  channel   direction  handshake         payload
//  in        sink       in_valid/in_stall  in_data (tdfa_pkg::in_t)
//  out       source     out_valid/out_stall out_data (tdfa_pkg::out_t)
//  cfg       sink       cfg_valid/cfg_ready cfg_data (start state)
//
//  one request beat per cycle sustained unless out_stall or a clear pass
//  holds it; throughput is set by the step loop: transition read, next state,
//  next read address, all on the single read port of the transition memory;
//  after reset in_stall stays high while the MAX_STATES << SYMBOL_BITS
//  transition valid bits (65536 by default) are swept clear
//  out_stall holds the pipeline in place; cfg_ready is always high
// ----------------------------------------------------------------------------
module table_driven_dfa_stepper_top #(
    parameter int MAX_STATES  = tdfa_pkg::MAX_STATES_DEF,
    parameter int SYMBOL_BITS = tdfa_pkg::SYMBOL_BITS_DEF,
    parameter int MARK_BITS   = tdfa_pkg::MARK_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  tdfa_pkg::in_t                in_data,
    output logic                         out_valid,
    input  logic                         out_stall,
    output tdfa_pkg::out_t               out_data,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [tdfa_pkg::STATE_W-1:0] cfg_data
);
    import tdfa_pkg::*;

    localparam int STATE_AW = $clog2(MAX_STATES);
    localparam int MARK_IW  = (MARK_BITS > 1) ? $clog2(MARK_BITS) : 1;
    localparam int ADDR_W   = STATE_AW + SYMBOL_BITS;
    localparam int NUM_SYMS = 1 << SYMBOL_BITS;

    function automatic logic below(input logic [31:0] value, input int limit);
        return value < 32'(limit);
    endfunction

    logic [STATE_W-1:0] start_reg;
    logic [STATE_W-1:0] cur_reg;
    logic               rej_reg;

    logic               s0_valid_reg;
    in_t                s0_item_reg;
    logic               s1_valid_reg;
    in_t                s1_item_reg;
    logic               s1_lookup_ok_reg;
    logic               s2_valid_reg;
    logic [STATE_W-1:0] s2_state_reg;
    logic               s2_rej_reg;
    logic               s2_attr_ok_reg;
    logic               out_valid_reg;
    out_t               out_data_reg;
    out_t               out_data_next;

    logic out_free, s2_free, s1_free, s0_free;
    logic s2_adv, s1_adv, s0_adv, in_acc;

    logic               tr_busy, at_busy, busy;
    logic               tr_wr_en;
    logic [ADDR_W-1:0]  tr_wr_addr, tr_rd_addr;
    logic               tr_rd_valid;
    logic [STATE_W-1:0] tr_rd_next;

    logic                 at_wr_en, at_is_mark;
    logic                 at_rd_stop;
    logic [MARK_BITS-1:0] at_rd_marks;

    logic [STATE_W-1:0] cur_new, cur_eff;
    logic               rej_new, lookup_ok, attr_ok;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
        end
        else if (cfg_valid)
        begin
            start_reg <= cfg_data;
        end
    end

    // pipeline flow
    assign busy     = tr_busy || at_busy;
    assign out_free = !out_valid_reg || !out_stall;
    assign s2_adv   = s2_valid_reg && out_free;
    assign s2_free  = !s2_valid_reg || out_free;
    assign s1_adv   = s1_valid_reg && s2_free;
    assign s1_free  = !s1_valid_reg || s2_free;
    assign s0_adv   = s0_valid_reg && s1_free;
    assign s0_free  = !s0_valid_reg || s1_free;
    assign in_stall = busy || !s0_free;
    assign in_acc   = in_valid && !in_stall;

    // next state of the item in stage 1
    always_comb
    begin
        cur_new = cur_reg;
        rej_new = rej_reg;
        case (s1_item_reg.req_type)
            REQ_RESTART:
            begin
                cur_new = start_reg;
                rej_new = 1'b0;
            end
            REQ_STEP:
            begin
                if (!rej_reg)
                begin
                    if (s1_lookup_ok_reg && tr_rd_valid)
                    begin
                        cur_new = tr_rd_next;
                    end
                    else
                    begin
                        rej_new = 1'b1;
                    end
                end
            end
            default:
            begin
                cur_new = cur_reg;
            end
        endcase
    end

    assign attr_ok   = !rej_new && below(32'(cur_new), MAX_STATES);
    assign cur_eff   = s1_valid_reg ? cur_new : cur_reg;
    assign lookup_ok = below(32'(cur_eff), MAX_STATES) &&
                       below(32'(s0_item_reg.symbol), NUM_SYMS);

    // table writes in stage 0
    assign tr_wr_en   = s0_adv && (s0_item_reg.req_type == REQ_LOAD) &&
                        below(32'(s0_item_reg.from_state), MAX_STATES) &&
                        below(32'(s0_item_reg.symbol), NUM_SYMS);
    assign tr_wr_addr = {STATE_AW'(s0_item_reg.from_state),
                         SYMBOL_BITS'(s0_item_reg.symbol)};
    assign tr_rd_addr = {STATE_AW'(cur_eff), SYMBOL_BITS'(s0_item_reg.symbol)};

    assign at_is_mark = (s0_item_reg.req_type == REQ_MARK);
    assign at_wr_en   = s0_adv && below(32'(s0_item_reg.from_state), MAX_STATES) &&
                        ((s0_item_reg.req_type == REQ_STOP) ||
                         (at_is_mark && below(32'(s0_item_reg.mark_index), MARK_BITS)));

    tdfa_trans_mem #(
        .MAX_STATES  (MAX_STATES),
        .SYMBOL_BITS (SYMBOL_BITS)
    ) u_trans_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (tr_wr_en),
        .wr_addr  (tr_wr_addr),
        .wr_next  (s0_item_reg.to_state),
        .rd_en    (s0_adv),
        .rd_addr  (tr_rd_addr),
        .rd_valid (tr_rd_valid),
        .rd_next  (tr_rd_next),
        .busy     (tr_busy)
    );

    tdfa_attr_mem #(
        .MAX_STATES (MAX_STATES),
        .MARK_BITS  (MARK_BITS)
    ) u_attr_mem (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (at_wr_en),
        .wr_is_mark (at_is_mark),
        .wr_addr    (STATE_AW'(s0_item_reg.from_state)),
        .wr_bit     (MARK_IW'(s0_item_reg.mark_index)),
        .wr_value   (s0_item_reg.flag_value),
        .rd_en      (s1_adv),
        .rd_addr    (STATE_AW'(cur_new)),
        .rd_stop    (at_rd_stop),
        .rd_marks   (at_rd_marks),
        .busy       (at_busy)
    );

    // result of stage 2
    always_comb
    begin
        out_data_next = '0;
        if (s2_rej_reg)
        begin
            out_data_next.rejected = 1'b1;
        end
        else
        begin
            out_data_next.cur_state = s2_state_reg;
            out_data_next.accepting = s2_attr_ok_reg && at_rd_stop;
            out_data_next.mark_mask = s2_attr_ok_reg ? MASK_W'(at_rd_marks) : '0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cur_reg       <= '0;
            rej_reg       <= 1'b0;
        end
        else
        begin
            if (s0_free)
            begin
                s0_valid_reg <= in_acc;
            end
            if (s1_free)
            begin
                s1_valid_reg <= s0_valid_reg;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_free)
            begin
                out_valid_reg <= s2_valid_reg;
            end
            if (s1_adv)
            begin
                cur_reg <= cur_new;
                rej_reg <= rej_new;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s0_item_reg <= in_data;
        end
        if (s0_adv)
        begin
            s1_item_reg      <= s0_item_reg;
            s1_lookup_ok_reg <= lookup_ok;
        end
        if (s1_adv)
        begin
            s2_state_reg   <= cur_new;
            s2_rej_reg     <= rej_new;
            s2_attr_ok_reg <= attr_ok;
        end
        if (s2_adv)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> in_stall)
        else $error("request beat taken during clear pass");

    a_reject_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        rej_reg && !(s1_adv && (s1_item_reg.req_type == REQ_RESTART)) |=> rej_reg)
        else $error("reject left without restart");

    a_restart_state: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv && (s1_item_reg.req_type == REQ_RESTART) |=>
            !rej_reg && (cur_reg == $past(start_reg)))
        else $error("restart did not load start state");

    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(s1_adv && ((s1_item_reg.req_type == REQ_STEP) ||
                     (s1_item_reg.req_type == REQ_RESTART))) |=> $stable(cur_reg))
        else $error("state moved without step or restart");

endmodule

FILE: hdl/tdfa_trans_mem.sv
// ----------------------------------------------------------------------------
// tdfa_trans_mem
// transition memory: one word per (state, symbol) holding a valid bit and
// the destination state, with a clearing pass of the valid bits after reset
// ----------------------------------------------------------------------------
module tdfa_trans_mem #(
    parameter int MAX_STATES  = tdfa_pkg::MAX_STATES_DEF,
    parameter int SYMBOL_BITS = tdfa_pkg::SYMBOL_BITS_DEF,
    parameter int STATE_AW    = $clog2(MAX_STATES),
    parameter int ADDR_W      = STATE_AW + SYMBOL_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         wr_en,
    input  logic [ADDR_W-1:0]            wr_addr,
    input  logic [tdfa_pkg::STATE_W-1:0] wr_next,
    input  logic                         rd_en,
    input  logic [ADDR_W-1:0]            rd_addr,
    output logic                         rd_valid,
    output logic [tdfa_pkg::STATE_W-1:0] rd_next,
    output logic                         busy
);
    import tdfa_pkg::*;

    localparam int DEPTH = MAX_STATES << SYMBOL_BITS;
    localparam logic [ADDR_W-1:0] LAST = ADDR_W'(DEPTH - 1);

    logic [STATE_W:0]  mem [DEPTH];
    logic [STATE_W:0]  rd_data_reg;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic              busy_reg;

    // clearing sweep, one entry per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            busy_reg     <= 1'b1;
        end
        else if (busy_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == LAST)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (wr_en)
        begin
            mem[wr_addr] <= {1'b1, wr_next};
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_valid = rd_data_reg[STATE_W];
    assign rd_next  = rd_data_reg[STATE_W-1:0];
    assign busy     = busy_reg;

    a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |=> !busy_reg)
        else $error("transition clear pass restarted");

    a_clear_walk: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && (clr_addr_reg != LAST) |=>
            busy_reg && (clr_addr_reg == $past(clr_addr_reg) + 1'b1))
        else $error("transition clear pass skipped an entry");

    a_no_write_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !wr_en)
        else $error("transition write during clear pass");

endmodule

FILE: hdl/tdfa_attr_mem.sv
// ----------------------------------------------------------------------------
// tdfa_attr_mem
// per-state stop flag and mark bits, single bit writes, registered read,
// cleared by a sweep after reset
// ----------------------------------------------------------------------------
module tdfa_attr_mem #(
    parameter int MAX_STATES = tdfa_pkg::MAX_STATES_DEF,
    parameter int MARK_BITS  = tdfa_pkg::MARK_BITS_DEF,
    parameter int STATE_AW   = $clog2(MAX_STATES),
    parameter int MARK_IW    = (MARK_BITS > 1) ? $clog2(MARK_BITS) : 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic                 wr_is_mark,
    input  logic [STATE_AW-1:0]  wr_addr,
    input  logic [MARK_IW-1:0]   wr_bit,
    input  logic                 wr_value,
    input  logic                 rd_en,
    input  logic [STATE_AW-1:0]  rd_addr,
    output logic                 rd_stop,
    output logic [MARK_BITS-1:0] rd_marks,
    output logic                 busy
);
    import tdfa_pkg::*;

    localparam logic [STATE_AW-1:0] LAST = STATE_AW'(MAX_STATES - 1);

    logic                 stop_mem [MAX_STATES];
    logic [MARK_BITS-1:0] mark_mem [MAX_STATES];
    logic                 stop_rd_reg;
    logic [MARK_BITS-1:0] marks_rd_reg;
    logic [STATE_AW-1:0]  clr_addr_reg;
    logic                 busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            busy_reg     <= 1'b1;
        end
        else if (busy_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == LAST)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            stop_mem[clr_addr_reg] <= 1'b0;
            mark_mem[clr_addr_reg] <= '0;
        end
        else if (wr_en)
        begin
            if (wr_is_mark)
            begin
                mark_mem[wr_addr][wr_bit] <= wr_value;
            end
            else
            begin
                stop_mem[wr_addr] <= wr_value;
            end
        end
        if (rd_en)
        begin
            stop_rd_reg  <= stop_mem[rd_addr];
            marks_rd_reg <= mark_mem[rd_addr];
        end
    end

    assign rd_stop  = stop_rd_reg;
    assign rd_marks = marks_rd_reg;
    assign busy     = busy_reg;

    a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |=> !busy_reg)
        else $error("attribute clear pass restarted");

    a_clear_walk: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && (clr_addr_reg != LAST) |=>
            busy_reg && (clr_addr_reg == $past(clr_addr_reg) + 1'b1))
        else $error("attribute clear pass skipped an entry");

    a_no_write_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !wr_en)
        else $error("attribute write during clear pass");

endmodule
